// ===== hdl/cbq_pkg.sv =====
// Shared types, constants and helpers for the stereo cascaded biquad filter.
// No dependencies; every other file of the block depends on this package.
package cbq_pkg;

	localparam int MAX_SECTIONS_DEF = 16;
	localparam int SAMPLE_WIDTH     = 24;
	localparam int COEF_WIDTH       = 32;
	localparam int TAPS             = 5;
	localparam int FRAC_SHIFT       = COEF_WIDTH - 4;
	localparam int ACC_WIDTH        = SAMPLE_WIDTH + COEF_WIDTH + 3;
	localparam int PROD_WIDTH       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int HIST_WIDTH       = 4 * SAMPLE_WIDTH;

	localparam int RATE_WIDTH  = 19;
	localparam int COUNT_WIDTH = 5;
	localparam logic [RATE_WIDTH-1:0] RATE_A = 19'd44100;
	localparam logic [RATE_WIDTH-1:0] RATE_B = 19'd48000;

	localparam int PADDR_WIDTH = 4;
	localparam int PDATA_WIDTH = 32;

	// input tdata layout
	localparam int OFF_LEFT      = 0;
	localparam int OFF_RIGHT     = OFF_LEFT + SAMPLE_WIDTH;
	localparam int OFF_BANK      = OFF_RIGHT + SAMPLE_WIDTH;
	localparam int SECTION_W     = 4;
	localparam int OFF_SECTION   = OFF_BANK + 1;
	localparam int SLOT_W        = 3;
	localparam int OFF_SLOT      = OFF_SECTION + SECTION_W;
	localparam int OFF_VALUE     = OFF_SLOT + SLOT_W;
	localparam int IN_DATA_WIDTH = OFF_VALUE + COEF_WIDTH;
	localparam int OUT_DATA_WIDTH = 2 * SAMPLE_WIDTH;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	typedef enum logic [1:0] {
		REG_ENABLE,
		REG_RATE,
		REG_COUNT
	} reg_idx_t;

	typedef enum logic [SLOT_W-1:0] {
		SLOT_B0,
		SLOT_B1,
		SLOT_B2,
		SLOT_A1,
		SLOT_A2
	} coef_slot_t;

	// MAC order within a section; the new input goes last so the previous
	// section's output has time to settle.
	typedef enum logic [2:0] {
		OP_X1,
		OP_X2,
		OP_Y1,
		OP_Y2,
		OP_X
	} op_sel_t;

	typedef struct packed {
		logic    load;
		logic    hist_rd;
		logic    mul_en;
		op_sel_t op_sel;
		logic    acc_init;
		logic    acc_add;
		logic    fin;
		logic    hist_clr;
	} lane_ctl_t;

	function automatic int addr_w(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// coefficients are stored in MAC order
	function automatic op_sel_t slot_pos(logic [SLOT_W-1:0] slot);
		op_sel_t p;
		case (slot)
			SLOT_B0: p = OP_X;
			SLOT_B1: p = OP_X1;
			SLOT_B2: p = OP_X2;
			SLOT_A1: p = OP_Y1;
			SLOT_A2: p = OP_Y2;
			default: p = OP_X;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/cbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on cbq_pkg for the address width helper.
module cbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = cbq_pkg::addr_w(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cbq_lane.sv =====
// One channel lane: multiplier, accumulator, rounding/saturation and the
// per-section history memory. Depends on cbq_pkg and cbq_ram.
module cbq_lane #(
	parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF,
	localparam int HAW         = cbq_pkg::addr_w(MAX_SECTIONS)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cbq_pkg::lane_ctl_t                      ctl,
	input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  logic signed [cbq_pkg::COEF_WIDTH-1:0]   coef_in,
	input  logic [HAW-1:0]                          hist_raddr,
	input  logic [HAW-1:0]                          hist_waddr,
	output logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] x_out
);
	import cbq_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int UW = ACC_WIDTH - FRAC_SHIFT - SW + 1;
	localparam logic signed [ACC_WIDTH-1:0] ROUND = ACC_WIDTH'(1) << (FRAC_SHIFT - 1);
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	logic signed [SW-1:0]         x_q;
	logic signed [PROD_WIDTH-1:0] prod_s1;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic [MAX_SECTIONS-1:0]      valid_q;
	logic                         row_ok_q;

	logic [HIST_WIDTH-1:0]        row_rd;
	logic [HIST_WIDTH-1:0]        row_wr;
	logic signed [SW-1:0]         h_x1, h_x2, h_y1, h_y2;
	logic signed [SW-1:0]         operand;
	logic signed [ACC_WIDTH-1:0]  sum;
	logic [UW-1:0]                upper;
	logic signed [SW-1:0]         y;

	cbq_ram #(
		.WIDTH(HIST_WIDTH),
		.DEPTH(MAX_SECTIONS)
	) u_hist (
		.clk  (clk),
		.we   (ctl.fin),
		.waddr(hist_waddr),
		.wdata(row_wr),
		.re   (ctl.hist_rd),
		.raddr(hist_raddr),
		.rdata(row_rd)
	);

	// a row never written since the last clear reads as zero
	assign h_x1 = row_ok_q ? row_rd[0*SW +: SW] : '0;
	assign h_x2 = row_ok_q ? row_rd[1*SW +: SW] : '0;
	assign h_y1 = row_ok_q ? row_rd[2*SW +: SW] : '0;
	assign h_y2 = row_ok_q ? row_rd[3*SW +: SW] : '0;

	always_comb begin
		case (ctl.op_sel)
			OP_X1:   operand = h_x1;
			OP_X2:   operand = h_x2;
			OP_Y1:   operand = h_y1;
			OP_Y2:   operand = h_y2;
			OP_X:    operand = x_q;
			default: operand = x_q;
		endcase
	end

	// last product folds in here; rounding offset was preloaded into acc
	assign sum   = acc_q + ACC_WIDTH'(prod_s1);
	assign upper = sum[ACC_WIDTH-1 -: UW];

	always_comb begin
		if (&upper || ~|upper) begin
			y = sum[FRAC_SHIFT +: SW];
		end else if (sum[ACC_WIDTH-1]) begin
			y = S_MIN;
		end else begin
			y = S_MAX;
		end
	end

	assign row_wr = {h_y1, y, h_x1, x_q};

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= operand * coef_in;
		end
		if (ctl.acc_init) begin
			acc_q <= ROUND;
		end else if (ctl.acc_add) begin
			acc_q <= sum;
		end
		if (ctl.load) begin
			x_q <= sample_in;
		end else if (ctl.fin) begin
			x_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			row_ok_q <= 1'b0;
		end else begin
			if (ctl.hist_clr) begin
				valid_q <= '0;
			end else if (ctl.fin) begin
				valid_q[hist_waddr] <= 1'b1;
			end
			if (ctl.hist_rd) begin
				row_ok_q <= valid_q[hist_raddr];
			end
		end
	end

	assign x_out = x_q;

endmodule

// ===== hdl/cbq_ctrl.sv =====
// Configuration registers, section/phase sequencer, coefficient write decode
// and the output register that merges both lanes. Depends on cbq_pkg.
module cbq_ctrl #(
	parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF,
	localparam int HAW         = cbq_pkg::addr_w(MAX_SECTIONS),
	localparam int CAW         = cbq_pkg::addr_w(2 * MAX_SECTIONS * cbq_pkg::TAPS)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [cbq_pkg::PADDR_WIDTH-1:0]         paddr,
	input  logic [cbq_pkg::PDATA_WIDTH-1:0]         pwdata,
	output logic [cbq_pkg::PDATA_WIDTH-1:0]         prdata,
	output logic                                    pready,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [cbq_pkg::IN_DATA_WIDTH-1:0]       s_axis_tdata,
	input  logic                                    s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [cbq_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata,
	input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] res_left,
	input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] res_right,
	output logic                                    coef_we,
	output logic [CAW-1:0]                          coef_waddr,
	output logic [cbq_pkg::COEF_WIDTH-1:0]          coef_wdata,
	output logic                                    coef_re,
	output logic [CAW-1:0]                          coef_raddr,
	output logic [HAW-1:0]                          hist_raddr,
	output logic [HAW-1:0]                          hist_waddr,
	output cbq_pkg::lane_ctl_t                      ctl
);
	import cbq_pkg::*;

	localparam int SCW = $clog2(MAX_SECTIONS + 1);
	localparam logic [2:0] PH_LAST = 3'(TAPS);
	localparam logic [CAW-1:0] BANK1_BASE = CAW'(MAX_SECTIONS * TAPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PUSH
	} state_t;

	state_t                        state_q;
	logic [SCW-1:0]                sec_q;
	logic [2:0]                    ph_q;
	logic [CAW-1:0]                caddr_q;
	logic                          m_tvalid_q;
	logic [OUT_DATA_WIDTH-1:0]     m_tdata_q;

	logic                          enable_q;
	logic [RATE_WIDTH-1:0]         rate_q;
	logic [COUNT_WIDTH-1:0]        count_q;

	logic                          cfg_wr;
	reg_idx_t                      reg_idx;
	logic                          hist_clr;
	logic                          rate_ok;
	logic                          bank;
	logic [SCW-1:0]                cnt_eff;
	logic                          active;
	logic                          accept;
	logic                          is_coef;
	logic                          live;
	logic                          run;
	logic                          push;
	logic [SCW-1:0]                sec_m1;
	logic [SECTION_W-1:0]          wr_section;
	logic [SLOT_W-1:0]             wr_slot;
	logic                          wr_bank;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_idx)
			REG_ENABLE: prdata = PDATA_WIDTH'(enable_q);
			REG_RATE:   prdata = PDATA_WIDTH'(rate_q);
			REG_COUNT:  prdata = PDATA_WIDTH'(count_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		hist_clr = 1'b0;
		if (cfg_wr) begin
			case (reg_idx)
				REG_ENABLE: hist_clr = pwdata[0] && !enable_q;
				REG_RATE:   hist_clr = pwdata[RATE_WIDTH-1:0] != rate_q;
				REG_COUNT:  hist_clr = 1'b1;
				default:    hist_clr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_q   <= RATE_A;
			count_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_RATE:   rate_q   <= pwdata[RATE_WIDTH-1:0];
				REG_COUNT:  count_q  <= pwdata[COUNT_WIDTH-1:0];
				default:    ;
			endcase
		end
	end

	assign rate_ok = (rate_q == RATE_A) || (rate_q == RATE_B);
	assign bank    = rate_q == RATE_B;
	assign cnt_eff = (32'(count_q) > MAX_SECTIONS) ? SCW'(MAX_SECTIONS) : SCW'(count_q);
	assign active  = enable_q && (cnt_eff != '0) && rate_ok;

	// input side
	assign s_axis_tready = state_q == ST_IDLE;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_coef       = s_axis_tuser == CMD_COEF;

	assign wr_bank    = s_axis_tdata[OFF_BANK];
	assign wr_section = s_axis_tdata[OFF_SECTION +: SECTION_W];
	assign wr_slot    = s_axis_tdata[OFF_SLOT +: SLOT_W];
	assign coef_wdata = s_axis_tdata[OFF_VALUE +: COEF_WIDTH];
	assign coef_we    = accept && is_coef && (32'(wr_slot) < TAPS)
	                    && (32'(wr_section) < MAX_SECTIONS);
	assign coef_waddr = CAW'((32'(wr_bank) * MAX_SECTIONS + 32'(wr_section)) * TAPS
	                    + 32'(slot_pos(wr_slot)));

	// sequencer: six phases per section, phase 0 also closes the previous one
	assign run    = state_q == ST_RUN;
	assign live   = run && (sec_q < cnt_eff);
	assign sec_m1 = sec_q - SCW'(1);
	assign push   = (state_q == ST_PUSH) && (!m_tvalid_q || m_axis_tready);

	assign coef_re    = live && (ph_q < PH_LAST);
	assign coef_raddr = caddr_q;
	assign hist_raddr = sec_q[HAW-1:0];
	assign hist_waddr = sec_m1[HAW-1:0];

	always_comb begin
		ctl          = '0;
		ctl.load     = accept && !is_coef;
		ctl.hist_rd  = live && (ph_q == 3'd0);
		ctl.mul_en   = live && (ph_q != 3'd0);
		ctl.op_sel   = op_sel_t'(ph_q - 3'd1);
		ctl.acc_init = live && (ph_q == 3'd1);
		ctl.acc_add  = live && (ph_q >= 3'd2);
		ctl.fin      = run && (ph_q == 3'd0) && (sec_q != '0);
		ctl.hist_clr = hist_clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sec_q      <= '0;
			ph_q       <= '0;
			caddr_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (push) begin
				m_tdata_q  <= {res_right, res_left};
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (coef_re) begin
				caddr_q <= caddr_q + CAW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_coef) begin
						sec_q   <= '0;
						ph_q    <= '0;
						caddr_q <= bank ? BANK1_BASE : '0;
						state_q <= active ? ST_RUN : ST_PUSH;
					end
				end
				ST_RUN: begin
					if (sec_q == cnt_eff) begin
						state_q <= ST_PUSH;
					end else if (ph_q == PH_LAST) begin
						ph_q  <= '0;
						sec_q <= sec_q + SCW'(1);
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// ===== hdl/stereo_cascaded_biquad_filter.sv =====
// Top level of the stereo cascaded direct-form-I biquad filter.
// Depends on cbq_pkg, cbq_ram, cbq_lane and cbq_ctrl.
//
// Channel   Dir  Handshake                    Carries
// s_axis    in   tvalid/tready                sample pair or coefficient write
// m_axis    out  tvalid/tready                filtered sample pair
// apb       in   psel/penable/pwrite, pready  enable, sample_rate, section_count
//
// A coefficient write leaves the input ready. A bypassed item goes from idle straight to
// the push state; a filtered item with N sections first runs through them. Either way the
// input is held off until the result is pushed into the output register. Each lane has one
// multiplier, fed one coefficient per cycle from a shared memory port; a section is a read
// cycle plus five MACs, its closing add overlaps the next section's read cycle, and an
// extra step closes the last section.
// Reset clears control state and the history valid bits; the coefficient
// memory holds nothing usable until written. A result waits in the output
// register while the next item is taken; the following result waits in the
// sequencer until that register frees up.
module stereo_cascaded_biquad_filter #(
	parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cbq_pkg::PADDR_WIDTH-1:0]    paddr,
	input  logic [cbq_pkg::PDATA_WIDTH-1:0]    pwdata,
	output logic [cbq_pkg::PDATA_WIDTH-1:0]    prdata,
	output logic                               pready,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sample_left, sample_right, coef_bank, coef_section, coef_slot, coef_value
	input  logic [cbq_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
	// command
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_left, out_right
	output logic [cbq_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);
	import cbq_pkg::*;

	localparam int HAW = addr_w(MAX_SECTIONS);
	localparam int CD  = 2 * MAX_SECTIONS * TAPS;
	localparam int CAW = addr_w(CD);

	lane_ctl_t                    ctl;
	logic                         coef_we;
	logic [CAW-1:0]               coef_waddr;
	logic [COEF_WIDTH-1:0]        coef_wdata;
	logic                         coef_re;
	logic [CAW-1:0]               coef_raddr;
	logic [COEF_WIDTH-1:0]        coef_rdata;
	logic [HAW-1:0]               hist_raddr;
	logic [HAW-1:0]               hist_waddr;
	logic signed [SAMPLE_WIDTH-1:0] res_left;
	logic signed [SAMPLE_WIDTH-1:0] res_right;

	cbq_ctrl #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.res_left     (res_left),
		.res_right    (res_right),
		.coef_we      (coef_we),
		.coef_waddr   (coef_waddr),
		.coef_wdata   (coef_wdata),
		.coef_re      (coef_re),
		.coef_raddr   (coef_raddr),
		.hist_raddr   (hist_raddr),
		.hist_waddr   (hist_waddr),
		.ctl          (ctl)
	);

	cbq_ram #(
		.WIDTH(COEF_WIDTH),
		.DEPTH(CD)
	) u_coef (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_wdata),
		.re   (coef_re),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	cbq_lane #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample_in (s_axis_tdata[OFF_LEFT +: SAMPLE_WIDTH]),
		.coef_in   (coef_rdata),
		.hist_raddr(hist_raddr),
		.hist_waddr(hist_waddr),
		.x_out     (res_left)
	);

	cbq_lane #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample_in (s_axis_tdata[OFF_RIGHT +: SAMPLE_WIDTH]),
		.coef_in   (coef_rdata),
		.hist_raddr(hist_raddr),
		.hist_waddr(hist_waddr),
		.x_out     (res_right)
	);

endmodule

// ===== hdl/cbq_checker.sv =====
// Port-level checks for the stereo cascaded biquad filter, bound to the top.
// Depends on cbq_pkg and stereo_cascaded_biquad_filter.
module cbq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               s_axis_tuser,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [cbq_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);
	import cbq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a sample item always leaves the input held off in the cycle after it is taken
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SAMPLE) |=> !s_axis_tready)
		else $error("ready stayed high after a sample item");

	// coefficient writes never block the input
	a_coef_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_COEF) |=> s_axis_tready)
		else $error("ready dropped after a coefficient write");

	// a new result only follows a cycle in which the input was held off
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a sample item in flight");

endmodule

bind stereo_cascaded_biquad_filter cbq_checker u_cbq_checker (.*);
